/* hdl/wlms_pkg.sv */
// ----------------------------------------------------------------------------
// wlms_pkg: shared types for the weighted monotone subsequence unit
// Holds the width constants and the token that travels along the cell chain.
// ----------------------------------------------------------------------------
package wlms_pkg;

   localparam int DefaultMaxItems = 256;
   localparam int HeightWidth     = 16;
   localparam int WeightInWidth   = 16;
   localparam int TotalWidth      = 24;

   typedef logic [HeightWidth-1:0]   height_type;
   typedef logic [WeightInWidth-1:0] weight_type;
   typedef logic [TotalWidth-1:0]    total_type;

   // One item moving down the chain. While placed is low, inc and dec hold the
   // best chain weights seen so far among stored items; once placed is set
   // they hold the item's own final totals.
   typedef struct packed {
      logic       valid;
      logic       last;
      logic       placed;
      height_type height;
      weight_type width;
      total_type  inc;
      total_type  dec;
   } token_type;

endpackage

/* hdl/wlms_cell.sv */
// ----------------------------------------------------------------------------
// wlms_cell: one storage cell of the chain
// Holds one earlier item and folds it into every unplaced token that passes by.
// ----------------------------------------------------------------------------
module wlms_cell import wlms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  token_type tok_up,
   output token_type tok_down,
   output logic      occupied
);

   token_type  tok_ff, tok_in;
   logic       used_ff, used_in;
   height_type height_ff, height_in;
   total_type  inc_ff, inc_in;
   total_type  dec_ff, dec_in;
   total_type  inc_sum, dec_sum;

   function automatic total_type sat_add(input total_type a, input weight_type w);
      logic [TotalWidth:0] s;
      s = {1'b0, a} + {{(TotalWidth + 1 - WeightInWidth){1'b0}}, w};
      return s[TotalWidth] ? {TotalWidth{1'b1}} : s[TotalWidth-1:0];
   endfunction

   assign inc_sum = sat_add(tok_up.inc, tok_up.width);
   assign dec_sum = sat_add(tok_up.dec, tok_up.width);

   always_comb begin
      tok_in    = tok_up;
      used_in   = used_ff;
      height_in = height_ff;
      inc_in    = inc_ff;
      dec_in    = dec_ff;
      if (tok_up.valid && !tok_up.placed) begin
         if (used_ff) begin
            if (height_ff < tok_up.height && inc_ff > tok_up.inc) begin
               tok_in.inc = inc_ff;
            end
            if (height_ff > tok_up.height && dec_ff > tok_up.dec) begin
               tok_in.dec = dec_ff;
            end
         end else begin
            // First free cell: the item's totals are final here.
            tok_in.inc    = inc_sum;
            tok_in.dec    = dec_sum;
            tok_in.placed = 1'b1;
            if (!tok_up.last) begin
               used_in   = 1'b1;
               height_in = tok_up.height;
               inc_in    = inc_sum;
               dec_in    = dec_sum;
            end
         end
      end
      // The final item of a sequence empties every cell behind it.
      if (tok_up.valid && tok_up.last) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         used_ff <= 1'b0;
      end else if (advance) begin
         tok_ff  <= tok_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         height_ff <= height_in;
         inc_ff    <= inc_in;
         dec_ff    <= dec_in;
      end
   end

   assign tok_down = tok_ff;
   assign occupied = used_ff;

   // A stored item stays until a final item passes.
   assert property (@(posedge clock) disable iff (reset)
      used_ff && advance && !(tok_up.valid && tok_up.last) |=> used_ff)
      else $error("cell lost its stored item");

endmodule

/* hdl/wlms_tail.sv */
// ----------------------------------------------------------------------------
// wlms_tail: running maxima and result register
// Collects totals of tokens leaving the chain and issues one word per sequence.
// ----------------------------------------------------------------------------
module wlms_tail import wlms_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  token_type               tok_end,
   input  logic                    rsp_tready,
   output logic                    advance,
   output logic                    rsp_tvalid,
   output logic [2*TotalWidth-1:0] rsp_tdata,
   output logic [1:0]              rsp_tuser
);

   total_type inc_max_ff, inc_max_in, dec_max_ff, dec_max_in;
   logic      ovf_ff, ovf_in;
   logic      rsp_valid_ff, rsp_valid_in;
   total_type rsp_inc_ff, rsp_inc_in, rsp_dec_ff, rsp_dec_in;
   logic      rsp_first_ff, rsp_first_in, rsp_ovf_ff, rsp_ovf_in;
   total_type inc_new, dec_new;
   logic      ovf_new, stored;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign stored  = tok_end.valid && tok_end.placed;
   assign inc_new = (stored && tok_end.inc > inc_max_ff) ? tok_end.inc : inc_max_ff;
   assign dec_new = (stored && tok_end.dec > dec_max_ff) ? tok_end.dec : dec_max_ff;
   assign ovf_new = ovf_ff || (tok_end.valid && !tok_end.placed);

   always_comb begin
      inc_max_in   = inc_max_ff;
      dec_max_in   = dec_max_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_inc_in   = rsp_inc_ff;
      rsp_dec_in   = rsp_dec_ff;
      rsp_first_in = rsp_first_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (advance) begin
         rsp_valid_in = tok_end.valid && tok_end.last;
         if (tok_end.valid) begin
            if (tok_end.last) begin
               rsp_inc_in   = inc_new;
               rsp_dec_in   = dec_new;
               rsp_first_in = inc_new >= dec_new;
               rsp_ovf_in   = ovf_new;
               inc_max_in   = '0;
               dec_max_in   = '0;
               ovf_in       = 1'b0;
            end else begin
               inc_max_in = inc_new;
               dec_max_in = dec_new;
               ovf_in     = ovf_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_max_ff   <= '0;
         dec_max_ff   <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inc_max_ff   <= inc_max_in;
         dec_max_ff   <= dec_max_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inc_ff   <= rsp_inc_in;
      rsp_dec_ff   <= rsp_dec_in;
      rsp_first_ff <= rsp_first_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dec_ff, rsp_inc_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_first_ff};

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_first_ff == (rsp_inc_ff >= rsp_dec_ff)))
      else $error("order flag disagrees with totals");

   assert property (@(posedge clock) disable iff (reset)
      advance && tok_end.valid && !tok_end.placed && !tok_end.last |=> ovf_ff)
      else $error("dropped item did not set overflow");

   assert property (@(posedge clock) disable iff (reset)
      advance && tok_end.valid && tok_end.last
      |=> inc_max_ff == '0 && dec_max_ff == '0 && !ovf_ff)
      else $error("running state not cleared after a sequence");

endmodule

/* hdl/weighted_longest_monotone_subsequence_unit.sv */
// ----------------------------------------------------------------------------
// weighted_longest_monotone_subsequence_unit: weighted monotone chain finder
// Finds the heaviest strictly increasing and strictly decreasing height chains.
// ----------------------------------------------------------------------------
// Throughput: one word accepted per cycle while the result register is free.
// Result: issued from the result register once the final word has walked
//   through all MAX_ITEMS cells of the chain.
// Reset: synchronous, active high; empties every cell and the running maxima.
//   Stored cell contents are not cleared, only their occupied bits.
// ----------------------------------------------------------------------------
//
// Each word enters cell 0 as a token and moves one cell per cycle. An occupied
// cell offers its stored weights to the token (increasing weight if its height
// is smaller, decreasing weight if larger). The first free cell adds the
// word's width with saturation and keeps the word. A word always enters behind
// its predecessor, so it reaches that predecessor's cell after the
// store. The final word of a sequence stores nothing and empties each
// cell it passes, so the next sequence starts on a clean chain right behind
// it. A word that finds every cell full leaves the chain unplaced and marks
// the sequence as overflowed. The whole chain stalls while a result waits.
//
module weighted_longest_monotone_subsequence_unit import wlms_pkg::*; #(
   parameter int MAX_ITEMS = DefaultMaxItems
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,  // height[15:0], width[31:16]
   input  logic                    req_tlast,  // last_item
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [2*TotalWidth-1:0] rsp_tdata,  // increasing_total, decreasing_total
   output logic [1:0]              rsp_tuser   // increasing_first, overflowed
);

   token_type            chain [0:MAX_ITEMS];
   token_type            head_tok;
   logic [MAX_ITEMS-1:0] occupied;
   logic                 advance;

   // New word becomes a token with empty running bests.
   always_comb begin
      head_tok        = '0;
      head_tok.valid  = req_tvalid;
      head_tok.last   = req_tlast;
      head_tok.placed = 1'b0;
      head_tok.height = req_tdata[HeightWidth-1:0];
      head_tok.width  = req_tdata[HeightWidth+WeightInWidth-1:HeightWidth];
   end

   assign chain[0]   = head_tok;
   assign req_tready = advance;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      wlms_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .tok_up   (chain[i]),
         .tok_down (chain[i+1]),
         .occupied (occupied[i])
      );
   end

   wlms_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .tok_end    (chain[MAX_ITEMS]),
      .rsp_tready (rsp_tready),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An unplaced ordinary word can only leave the chain if the final cell was
   // occupied, which in turn means the whole chain was full.
   assert property (@(posedge clock) disable iff (reset)
      chain[MAX_ITEMS].valid && !chain[MAX_ITEMS].placed && !chain[MAX_ITEMS].last
      |-> occupied[MAX_ITEMS-1])
      else $error("word dropped while the chain had room");

endmodule

/* verif/monotone_chain_checker.sv */
// ----------------------------------------------------------------------------
// monotone_chain_checker: predicts and checks the chain totals of the unit
// Watches both stream channels, tracks the words of the current sequence and
// compares each result word against the totals it predicts, field by field.
// ----------------------------------------------------------------------------
module monotone_chain_checker import wlms_pkg::*; #(
   parameter int MAX_ITEMS = DefaultMaxItems
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [31:0]             req_tdata,  // height[15:0], width[31:16]
   input  logic                    req_tlast,  // last_item
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [2*TotalWidth-1:0] rsp_tdata,  // increasing_total, decreasing_total
   input  logic [1:0]              rsp_tuser,  // increasing_first, overflowed
   output int                      mismatch_count,
   output int                      totals_pending
);

   typedef struct packed {
      total_type inc_total;
      total_type dec_total;
      logic      inc_first;
      logic      overflowed;
   } chain_totals_type;

   height_type       seen_heights [MAX_ITEMS];
   total_type        inc_ending [MAX_ITEMS];
   total_type        dec_ending [MAX_ITEMS];
   int               items_held;
   total_type        inc_peak;
   total_type        dec_peak;
   logic             dropped;
   chain_totals_type totals_due [$];

   initial begin
      mismatch_count = 0;
      totals_pending = 0;
   end

   function automatic total_type add_width_saturating(total_type base, weight_type w);
      logic [TotalWidth:0] sum;
      sum = {1'b0, base} + w;
      return sum[TotalWidth] ? '1 : sum[TotalWidth-1:0];
   endfunction

   // Folds one accepted word into the current sequence. Only entries below
   // items_held are read, and those were all written in this sequence.
   function automatic void absorb_word(height_type h, weight_type w, logic last);
      total_type        inc_best;
      total_type        dec_best;
      chain_totals_type totals;
      if (items_held < MAX_ITEMS) begin
         inc_best = '0;
         dec_best = '0;
         for (int j = 0; j < items_held; j++) begin
            if (seen_heights[j] < h && inc_ending[j] > inc_best)
               inc_best = inc_ending[j];
            if (seen_heights[j] > h && dec_ending[j] > dec_best)
               dec_best = dec_ending[j];
         end
         inc_best = add_width_saturating(inc_best, w);
         dec_best = add_width_saturating(dec_best, w);
         seen_heights[items_held] = h;
         inc_ending[items_held] = inc_best;
         dec_ending[items_held] = dec_best;
         items_held++;
         if (inc_best > inc_peak)
            inc_peak = inc_best;
         if (dec_best > dec_peak)
            dec_peak = dec_best;
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         totals.inc_total  = inc_peak;
         totals.dec_total  = dec_peak;
         totals.inc_first  = (inc_peak >= dec_peak);
         totals.overflowed = dropped;
         totals_due.push_back(totals);
         items_held = 0;
         inc_peak   = '0;
         dec_peak   = '0;
         dropped    = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : watch
      chain_totals_type want;
      if (reset) begin
         items_held = 0;
         inc_peak   = '0;
         dec_peak   = '0;
         dropped    = 1'b0;
         totals_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (totals_due.size() == 0) begin
               $error("result word with no totals expected: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = totals_due.pop_front();
               if (rsp_tdata[TotalWidth-1:0] !== want.inc_total) begin
                  $error("increasing_total: expected %0d, actual %0d",
                         want.inc_total, rsp_tdata[TotalWidth-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[2*TotalWidth-1:TotalWidth] !== want.dec_total) begin
                  $error("decreasing_total: expected %0d, actual %0d",
                         want.dec_total, rsp_tdata[2*TotalWidth-1:TotalWidth]);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== want.inc_first) begin
                  $error("increasing_first: expected %0d, actual %0d",
                         want.inc_first, rsp_tuser[0]);
                  mismatch_count++;
               end
               if (rsp_tuser[1] !== want.overflowed) begin
                  $error("overflowed: expected %0d, actual %0d",
                         want.overflowed, rsp_tuser[1]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_word(req_tdata[HeightWidth-1:0],
                        req_tdata[HeightWidth+WeightInWidth-1:HeightWidth], req_tlast);
      end
      totals_pending <= totals_due.size();
   end

endmodule

/* verif/weighted_longest_monotone_subsequence_unit_test.sv */
// ----------------------------------------------------------------------------
// weighted_longest_monotone_subsequence_unit_test: stimulus and verdict
// Drives sequences of height and width words into the unit, with random gaps
// and result stalls, and leaves prediction and checking to the checker.
// ----------------------------------------------------------------------------
module weighted_longest_monotone_subsequence_unit_test;
   import wlms_pkg::*;

   localparam int MaxItems     = DefaultMaxItems;
   localparam int RandomWords  = 1600;
   localparam int CycleLimit   = 1000000;
   // The final word walks the whole chain before its result shows up.
   localparam int DrainCycles  = MaxItems + 40;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [31:0]             req_tdata;   // height[15:0], width[31:16]
   logic                    req_tlast;   // last_item
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [2*TotalWidth-1:0] rsp_tdata;   // increasing_total, decreasing_total
   logic [1:0]              rsp_tuser;   // increasing_first, overflowed

   int   mismatch_count;
   int   totals_pending;
   int   cycle_count;
   int   random_words_sent;
   logic sender_calm;
   logic receiver_calm;

   weighted_longest_monotone_subsequence_unit #(
      .MAX_ITEMS (MaxItems)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   monotone_chain_checker #(
      .MAX_ITEMS (MaxItems)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .totals_pending (totals_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the unit hangs or never answers a final word.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one word after a random gap and holds it until it is taken. When
   // the gap is zero, tvalid simply stays high into the next word.
   task automatic send_word(input height_type h, input weight_type w, input logic last);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {w, h};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // Sends one whole sequence with random content. The shape picks how the
   // heights move: anywhere, within a few values so that ties are common, or
   // drifting up or down so that long chains form.
   task automatic send_sequence(input int length);
      int         shape;
      int         pick;
      height_type h;
      weight_type w;
      shape = $urandom_range(0, 3);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < length; i++) begin
         case (shape)
            0: begin
               h = height_type'($urandom_range(0, 65535));
            end
            1: begin
               h = height_type'($urandom_range(0, 7));
            end
            2: begin
               h = height_type'(i * 200 + $urandom_range(0, 300));
            end
            default: begin
               h = height_type'(65535 - (i * 200 + $urandom_range(0, 300)));
            end
         endcase
         pick = $urandom_range(0, 7);
         if (pick == 0)
            w = '0;
         else if (pick == 1)
            w = '1;
         else
            w = weight_type'($urandom_range(0, 65535));
         send_word(h, w, i == length - 1);
         random_words_sent++;
      end
   endtask

   // Result side: before each result word it stalls for a random number of
   // cycles, or not at all during calm stretches.
   initial begin
      rsp_tready = 1'b0;
      receiver_calm = 1'b0;
      @(negedge reset);
      forever begin : receive
         int stall;
         receiver_calm = ($urandom_range(0, 3) == 0);
         stall = receiver_calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int length;
      int sequence_index;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      sender_calm = 1'b0;
      random_words_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. A lone word at the bottom of both ranges gives a tie,
      // which must put the increasing total first.
      send_word(16'h0000, 16'h0000, 1'b1);
      // A lone word at the top of both ranges.
      send_word(16'hFFFF, 16'hFFFF, 1'b1);
      // Strictly rising heights: the increasing chain collects every width.
      send_word(16'h0000, 16'hFFFF, 1'b0);
      send_word(16'd100, 16'd1, 1'b0);
      send_word(16'hFFFF, 16'd2, 1'b1);
      // Strictly falling heights: the decreasing total wins.
      send_word(16'hFFFF, 16'd5, 1'b0);
      send_word(16'd300, 16'd7, 1'b0);
      send_word(16'h0000, 16'd9, 1'b1);
      // Equal heights never extend a chain, in either direction.
      send_word(16'd500, 16'd10, 1'b0);
      send_word(16'd500, 16'd10, 1'b0);
      send_word(16'd500, 16'd10, 1'b1);
      // Alternating bit patterns on both fields.
      send_word(16'hAAAA, 16'h5555, 1'b0);
      send_word(16'h5555, 16'hAAAA, 1'b0);
      send_word(16'hFFFF, 16'hFFFF, 1'b0);
      send_word(16'h0000, 16'h0000, 1'b1);

      // Random part. Most sequences are short; a few fill the chain exactly
      // or run past its capacity so that the overflow flag gets exercised.
      sequence_index = 0;
      while (random_words_sent < RandomWords) begin
         if (sequence_index == 2)
            length = MaxItems + 1;
         else if (sequence_index == 5)
            length = MaxItems;
         else if ($urandom_range(0, 49) == 0)
            length = $urandom_range(MaxItems - 1, MaxItems + 6);
         else
            length = $urandom_range(1, 24);
         send_sequence(length);
         sequence_index++;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Let every result arrive, then give the chain time to show anything
      // spurious before the verdict.
      while (totals_pending != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && totals_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
